// ----- hdl/bba_pkg.sv -----
// Package for the buddy block allocator: payload structs, sequencer states
// and default sizing constants. No dependencies.
package bba_pkg;

   localparam int NUM_ENTRIES_DEF = 512;
   localparam int MIN_BLOCK_DEF   = 32;
   localparam int MAX_BLOCK_DEF   = 16384;

   localparam logic [31:0] HEAP_BASE_RESET = 32'h2000_1000;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] req_size;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic        ok;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_NODE,
      S_A_LEAF,
      S_A_POP,
      S_A_MID,
      S_F_IDX,
      S_F_HEAD,
      S_F_LOOP,
      S_F_PAR,
      S_F_BUD,
      S_F_WR2
   } state_type;

endpackage

// ----- hdl/buddy_block_allocator_top.sv -----
// Buddy block allocator top level: sequencer, block table memory and stack.
// Depends on bba_pkg and bba_div.
// A request rejected on its size or address gets its result in the cycle
// after its transfer. An allocate goes down the tree one level at a time,
// tests each leaf it reaches and comes back up level by level. A free reads
// the block head, then at each merge level uses the divider to find the
// block's parity. The result strobe comes in the cycle after the outcome is
// known. One request at a time; the result strobe cannot be stalled. After
// reset a clearing pass over all NUM_ENTRIES table entries runs before the
// first request.
module buddy_block_allocator_top #(
   parameter int NUM_ENTRIES = bba_pkg::NUM_ENTRIES_DEF,
   parameter int MIN_BLOCK   = bba_pkg::MIN_BLOCK_DEF,
   parameter int MAX_BLOCK   = bba_pkg::MAX_BLOCK_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   output bba_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [31:0]      csr_wdata
);

   import bba_pkg::*;

   // Table sizing. Entries hold a block size in bytes with the used flag in
   // bit 0; two spare bits leave room for a merge that doubles a size.
   localparam int IdxW      = $clog2(NUM_ENTRIES);
   localparam int CntW      = IdxW + 1;
   localparam int HeapBytes = NUM_ENTRIES * MIN_BLOCK;
   localparam int SizeMax   = (MAX_BLOCK > HeapBytes) ? MAX_BLOCK : HeapBytes;
   localparam int EntW      = $clog2(SizeMax) + 2;
   localparam int OffW      = $clog2(HeapBytes);
   localparam int DivW      = (EntW > OffW) ? EntW : OffW;
   localparam int StkD      = IdxW + 1;
   localparam int StkIW     = $clog2(StkD);
   localparam int SpW       = $clog2(StkD + 1);
   // The minimum block is a power of two, so dividing by it is a shift.
   localparam int MinSh     = $clog2(MIN_BLOCK);

   localparam logic [31:0]     MinB    = 32'(MIN_BLOCK);
   localparam logic [31:0]     MaxB    = 32'(MAX_BLOCK);
   localparam logic [32:0]     TopOff  = 33'((NUM_ENTRIES - 1) * MIN_BLOCK);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_ENTRIES - 1);
   localparam logic [EntW-1:0] MaxEnt  = EntW'(MAX_BLOCK);
   localparam logic [DivW:0]   NumEnt  = (DivW + 1)'(NUM_ENTRIES);

   state_type state_ff, state_in;

   logic [31:0]     base_ff;
   logic [15:0]     size_ff, size_in;
   logic [31:0]     addr_ff, addr_in;
   logic [IdxW-1:0] lo_ff, lo_in;
   logic [IdxW-1:0] hi_ff, hi_in;
   logic [SpW-1:0]  sp_ff, sp_in;
   logic            succ_ff, succ_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [IdxW-1:0] bud_ff, bud_in;
   logic [EntW-1:0] ent_ff, ent_in;
   logic [DivW-1:0] disp_ff, disp_in;
   logic            even_ff, even_in;
   logic [IdxW-1:0] clr_ff, clr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   // Recursion stack of the depth-first search: one frame per split level.
   logic [IdxW-1:0] stk_lo_ff [StkD];
   logic [IdxW-1:0] stk_hi_ff [StkD];
   logic            stk_ph_ff [StkD];
   logic            stk_we;
   logic [StkIW-1:0] stk_wa;
   logic [IdxW-1:0] stk_wlo, stk_whi;
   logic            stk_wph;

   // Block table memory, single address, registered read.
   logic [EntW-1:0] table_mem [NUM_ENTRIES];
   logic [EntW-1:0] mem_q_ff;
   logic [IdxW-1:0] mem_addr;
   logic            mem_we;
   logic [EntW-1:0] mem_wdata;

   // Divider for the parity test of the free path.
   logic            div_start;
   logic [DivW-1:0] div_num, div_den;
   logic            div_done;
   logic [DivW-1:0] div_quot;

   // Current search node.
   logic [CntW-1:0] cnt, hcnt;
   logic [IdxW-1:0] mid;
   logic [31:0]     whole32, half32;
   logic            split;
   logic            leaf_ok;

   // Frame on top of the stack.
   logic [SpW-1:0]  sp_top;
   logic [StkIW-1:0] tix;
   logic [IdxW-1:0] f_lo, f_hi;
   logic            f_ph;
   logic [CntW-1:0] fcnt, fhcnt;
   logic [IdxW-1:0] fmid;

   // Free path.
   logic [32:0]     base33, a33;
   logic            rng_ok, size_ok;
   logic [31:0]     off32;
   logic [EntW-1:0] head;
   logic            head_ok, ent_small;
   logic [DivW:0]   bsum;
   logic [DivW-1:0] bdiff;
   logic            even_stop, odd_stop, bud_match;
   logic [EntW-1:0] ent2;
   logic [31:0]     alloc_addr;

   bba_div #(
      .W(DivW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .done    (div_done),
      .quotient(div_quot)
   );

   assign cnt     = CntW'({1'b0, hi_ff}) - CntW'({1'b0, lo_ff}) + CntW'(1);
   assign hcnt    = cnt >> 1;
   assign mid     = lo_ff + hcnt[IdxW-1:0];
   assign whole32 = 32'(cnt) * MinB;
   assign half32  = 32'(hcnt) * MinB;
   assign split   = (hcnt != '0) && (32'(size_ff) <= half32);
   assign leaf_ok = !mem_q_ff[0] && (32'(mem_q_ff) >= whole32);

   assign sp_top = sp_ff - SpW'(1);
   assign tix    = sp_top[StkIW-1:0];
   assign f_lo   = stk_lo_ff[tix];
   assign f_hi   = stk_hi_ff[tix];
   assign f_ph   = stk_ph_ff[tix];
   assign fcnt   = CntW'({1'b0, f_hi}) - CntW'({1'b0, f_lo}) + CntW'(1);
   assign fhcnt  = fcnt >> 1;
   assign fmid   = f_lo + fhcnt[IdxW-1:0];

   assign base33  = {1'b0, base_ff};
   assign a33     = {1'b0, req_data.free_address};
   assign rng_ok  = (a33 >= base33) && (a33 <= base33 + TopOff);
   assign off32   = req_data.free_address - base_ff;
   assign size_ok = (32'(req_data.req_size) >= MinB) && (32'(req_data.req_size) <= MaxB);

   // Buddy of the current block sits one block size (in entries) away.
   assign head      = {mem_q_ff[EntW-1:1], 1'b0};
   assign head_ok   = 32'(head) >= MinB;
   assign ent_small = 32'(ent_ff) < MinB;
   assign bsum      = (DivW + 1)'(idx_ff) + {1'b0, disp_ff};
   assign bdiff     = DivW'(idx_ff) - disp_ff;
   assign even_stop = bsum >= NumEnt;
   assign odd_stop  = DivW'(idx_ff) < disp_ff;
   assign bud_match = !mem_q_ff[0] && (head == ent_ff);
   assign ent2      = {ent_ff[EntW-2:0], 1'b0};

   assign alloc_addr = base_ff + 32'(idx_ff) * MinB;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LastIdx) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_data.action == ACTION_ALLOC) begin
                  if (size_ok) state_in = S_A_NODE;
               end else if (rng_ok) begin
                  state_in = S_F_IDX;
               end
            end
         end
         S_A_NODE: begin
            if (!split) state_in = S_A_LEAF;
         end
         S_A_LEAF: state_in = S_A_POP;
         S_A_POP: begin
            if (sp_ff == '0) begin
               state_in = S_IDLE;
            end else if (!succ_ff && !f_ph) begin
               state_in = S_A_NODE;
            end else if (succ_ff && !f_ph) begin
               state_in = S_A_MID;
            end
         end
         S_A_MID: state_in = S_A_POP;
         S_F_IDX: state_in = S_F_HEAD;
         S_F_HEAD: state_in = head_ok ? S_F_LOOP : S_IDLE;
         S_F_LOOP: state_in = ent_small ? S_IDLE : S_F_PAR;
         S_F_PAR: begin
            if (div_done) begin
               if (!div_quot[0]) state_in = even_stop ? S_IDLE : S_F_BUD;
               else              state_in = odd_stop ? S_IDLE : S_F_BUD;
            end
         end
         S_F_BUD: state_in = bud_match ? S_F_WR2 : S_IDLE;
         S_F_WR2: state_in = S_F_LOOP;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory and stack controls.
   always_comb begin
      size_in      = size_ff;
      addr_in      = addr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sp_in        = sp_ff;
      succ_in      = succ_ff;
      idx_in       = idx_ff;
      bud_in       = bud_ff;
      ent_in       = ent_ff;
      disp_in      = disp_ff;
      even_in      = even_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_addr     = lo_ff;
      mem_we       = 1'b0;
      mem_wdata    = '0;
      stk_we       = 1'b0;
      stk_wa       = sp_ff[StkIW-1:0];
      stk_wlo      = lo_ff;
      stk_whi      = hi_ff;
      stk_wph      = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = disp_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_addr  = clr_ff;
            mem_we    = 1'b1;
            mem_wdata = (clr_ff == '0) ? MaxEnt : '0;
            clr_in    = clr_ff + IdxW'(1);
         end
         S_IDLE: begin
            if (start) begin
               size_in = req_data.req_size;
               addr_in = req_data.free_address;
               lo_in   = '0;
               hi_in   = LastIdx;
               sp_in   = '0;
               succ_in = 1'b0;
               if (req_data.action == ACTION_ALLOC) begin
                  if (!size_ok) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_address: '0, ok: 1'b0};
                  end
               end else if (!rng_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_address: '0, ok: 1'b0};
               end else begin
                  idx_in = off32[IdxW+MinSh-1:MinSh];
               end
            end
         end
         S_A_NODE: begin
            mem_addr = lo_ff;
            if (split) begin
               stk_we  = 1'b1;
               stk_wph = 1'b0;
               sp_in   = sp_ff + SpW'(1);
               hi_in   = mid - IdxW'(1);
            end
         end
         S_A_LEAF: begin
            mem_addr = lo_ff;
            succ_in  = leaf_ok;
            if (leaf_ok) begin
               mem_we    = 1'b1;
               mem_wdata = EntW'(whole32) | EntW'(1);
               idx_in    = lo_ff;
            end
         end
         S_A_POP: begin
            mem_addr = fmid;
            if (sp_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_address: succ_ff ? alloc_addr : '0, ok: succ_ff};
            end else if (!succ_ff && !f_ph) begin
               // Left half failed: try the right half of the same node.
               stk_we  = 1'b1;
               stk_wa  = tix;
               stk_wlo = f_lo;
               stk_whi = f_hi;
               stk_wph = 1'b1;
               lo_in   = fmid;
               hi_in   = f_hi;
            end else begin
               sp_in = sp_top;
               lo_in = f_lo;
               hi_in = f_hi;
            end
         end
         S_A_MID: begin
            // A left-half success leaves the midpoint buddy free.
            mem_addr = mid;
            if (!mem_q_ff[0]) begin
               mem_we    = 1'b1;
               mem_wdata = EntW'(half32);
            end
         end
         S_F_IDX: begin
            mem_addr = idx_ff;
         end
         S_F_HEAD: begin
            mem_addr = idx_ff;
            if (head_ok) begin
               mem_we    = 1'b1;
               mem_wdata = head;
               ent_in    = head;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_address: '0, ok: 1'b0};
            end
         end
         S_F_LOOP: begin
            mem_addr = idx_ff;
            if (ent_small) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_address: addr_ff, ok: 1'b1};
            end else begin
               // Block size in entries, then the parity of idx over it.
               disp_in   = DivW'(ent_ff >> MinSh);
               div_start = 1'b1;
               div_num   = DivW'(idx_ff);
            end
         end
         S_F_PAR: begin
            mem_addr = idx_ff;
            if (div_done) begin
               even_in = !div_quot[0];
               if (!div_quot[0]) begin
                  mem_addr = bsum[IdxW-1:0];
                  bud_in   = bsum[IdxW-1:0];
                  if (even_stop) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_address: addr_ff, ok: 1'b1};
                  end
               end else begin
                  mem_addr = bdiff[IdxW-1:0];
                  bud_in   = bdiff[IdxW-1:0];
                  if (odd_stop) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_address: addr_ff, ok: 1'b1};
                  end
               end
            end
         end
         S_F_BUD: begin
            mem_addr = even_ff ? bud_ff : idx_ff;
            if (bud_match) begin
               mem_we    = 1'b1;
               mem_wdata = '0;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_address: addr_ff, ok: 1'b1};
            end
         end
         S_F_WR2: begin
            // The merged block is headed by the lower of the two buddies.
            mem_addr  = even_ff ? idx_ff : bud_ff;
            mem_we    = 1'b1;
            mem_wdata = ent2;
            ent_in    = ent2;
            if (!even_ff) idx_in = bud_ff;
         end
         default: begin
            mem_addr = lo_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_addr] <= mem_wdata;
      mem_q_ff <= table_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_lo_ff[stk_wa] <= stk_wlo;
         stk_hi_ff[stk_wa] <= stk_whi;
         stk_ph_ff[stk_wa] <= stk_wph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= HEAP_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) base_ff <= csr_wdata;
      end
      size_ff <= size_in;
      addr_ff <= addr_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      succ_ff <= succ_in;
      idx_ff  <= idx_in;
      bud_ff  <= bud_in;
      ent_ff  <= ent_in;
      disp_ff <= disp_in;
      even_ff <= even_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/bba_div.sv -----
// Restoring divider for the buddy block allocator, one quotient bit
// per cycle. No package dependencies.
module bba_div #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CntW = $clog2(W + 1);

   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [W:0]      shifted;
   logic [W:0]      trial;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CntW'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
